[hw/rtl/slrpg_pkg.sv]
// ----------------------------------------------------------------------------
// slrpg_pkg: shared types and constants for the stereo resampler
// Holds field widths, reset values, reciprocal constants, the register map,
// the sequencer state type and the structs that travel between modules.
// ----------------------------------------------------------------------------
package slrpg_pkg;

  // Field and datapath widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned PhaseW  = 35;
  localparam int unsigned GainW   = 7;
  localparam int unsigned PanW    = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MulW    = 24;
  localparam int unsigned ProdW   = 2 * MulW;
  // Magnitude of a gain product (below 2^22) and reciprocal shift
  localparam int unsigned MagW     = 23;
  localparam int unsigned DivShift = 29;
  localparam int unsigned QuoW     = SampleW + 1;

  localparam int unsigned MaxOutputsDefault = 8;

  // 3.32 phase of one source frame
  localparam logic [PhaseW-1:0] PhaseOne       = PhaseW'(64'h1_0000_0000);
  localparam logic [PhaseW-1:0] PhaseStepReset = PhaseOne;
  localparam logic [GainW-1:0]  VolumeReset    = GainW'(127);
  localparam logic [GainW-1:0]  OutGainReset   = GainW'(100);

  // ceil(2^29 / d): exact floor division for magnitudes below 2^22
  localparam logic [MulW-1:0] Recip127 = MulW'(4227331);
  localparam logic [MulW-1:0] Recip100 = MulW'(5368710);

  // Saturation limits of a signed sample, as magnitudes
  localparam logic [QuoW-1:0] SatPos = QuoW'(32767);
  localparam logic [QuoW-1:0] SatNeg = QuoW'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    REG_PHASE_STEP,
    REG_VOLUME_GAIN,
    REG_PAN_MODE,
    REG_OUT_GAIN
  } cfg_reg_e;

  typedef enum logic [PanW-1:0] {
    PAN_STEREO,
    PAN_LEFT,
    PAN_RIGHT,
    PAN_MUTE
  } pan_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VOL_L,
    S_DIV_L,
    S_VOL_R,
    S_DIV_R,
    S_LOAD,
    S_CHECK,
    S_INT_L,
    S_GAIN_L,
    S_GDIV_L,
    S_INT_R,
    S_GAIN_R,
    S_GDIV_R,
    S_FIN_R,
    S_EMIT
  } seq_state_e;

  typedef struct packed {
    logic signed [SampleW-1:0] source_left;
    logic signed [SampleW-1:0] source_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_left;
    logic signed [SampleW-1:0] out_right;
    logic                      last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase_step;
    logic [GainW-1:0]  volume_gain;
    pan_e              pan_mode;
    logic [GainW-1:0]  output_gain_percent;
  } cfg_t;

  typedef struct packed {
    logic                   en;
    logic signed [MulW-1:0] op_a;
    logic signed [MulW-1:0] op_b;
  } mul_req_t;

endpackage

[hw/rtl/slrpg_mul.sv]
// ----------------------------------------------------------------------------
// slrpg_mul: shared signed multiplier
// One 24x24 signed multiply per cycle with a registered product; the
// sequencer reuses it for volume, reciprocal division, interpolation and gain.
// ----------------------------------------------------------------------------
module slrpg_mul (
  input  logic                                  clk_i,
  input  slrpg_pkg::mul_req_t                   req_i,
  output logic signed [slrpg_pkg::ProdW-1:0]    prod_o
);
  import slrpg_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  // Capture the product only when the sequencer issues an operation
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.op_a * req_i.op_b;
    end
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/slrpg_seq.sv]
// ----------------------------------------------------------------------------
// slrpg_seq: frame sequencer and datapath
// Scales each source frame, keeps the previous and next frames and the phase,
// and steps the shared multiplier through interpolation and gain for every
// output frame. Owns the output register.
// ----------------------------------------------------------------------------
module slrpg_seq #(
  parameter int unsigned MaxOutputs = slrpg_pkg::MaxOutputsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slrpg_pkg::cfg_t        cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  slrpg_pkg::in_item_t    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output slrpg_pkg::out_item_t   out_data_o
);
  import slrpg_pkg::*;

  localparam int unsigned CntW = $clog2(MaxOutputs + 1);

  // Saturate a sign and magnitude pair to a signed sample
  function automatic logic [SampleW-1:0] sat_sample(input logic neg,
                                                    input logic [QuoW-1:0] mag);
    logic [QuoW-1:0] lim;
    logic [QuoW-1:0] mag_c;
    logic [QuoW-1:0] neg_c;
    lim   = neg ? SatNeg : SatPos;
    mag_c = (mag > lim) ? lim : mag;
    neg_c = ~mag_c + QuoW'(1);
    return neg ? neg_c[SampleW-1:0] : mag_c[SampleW-1:0];
  endfunction

  seq_state_e state_q, state_d;

  in_item_t               in_q;
  logic [SampleW-1:0]     lscale_q;
  logic                   sign_q;
  logic [SampleW-1:0]     prev_l_q, prev_r_q, next_l_q, next_r_q;
  logic [SampleW-1:0]     out_l_q, out_r_q;
  logic [PhaseW-1:0]      phase_q;
  logic [1:0]             prime_q;
  logic [CntW-1:0]        cnt_q;
  logic                   last_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  mul_req_t                mul_req;
  logic signed [ProdW-1:0] prod;

  logic [ProdW-1:0]   prod_abs;
  logic [MagW-1:0]    mag;
  logic [QuoW-1:0]    quo;
  logic [SampleW-1:0] qval;
  logic [SampleW:0]   diff_l, diff_r;
  logic [SampleW-1:0] interp_l, interp_r;
  logic [SampleW-1:0] frac;
  logic [PhaseW:0]    phase_sum;
  logic [PhaseW-1:0]  phase_inc;
  logic [CntW-1:0]    cnt_inc;
  logic               last_w;
  logic [SampleW-1:0] pan_l, pan_r;
  logic               push;

  slrpg_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Datapath helpers around the registered product
  always_comb begin
    prod_abs  = prod[ProdW-1] ? (~prod + ProdW'(1)) : prod;
    mag       = prod_abs[MagW-1:0];
    quo       = prod[DivShift+QuoW-1:DivShift];
    qval      = sat_sample(sign_q, quo);
    diff_l    = {next_l_q[SampleW-1], next_l_q} - {prev_l_q[SampleW-1], prev_l_q};
    diff_r    = {next_r_q[SampleW-1], next_r_q} - {prev_r_q[SampleW-1], prev_r_q};
    interp_l  = prev_l_q + prod[2*SampleW-1:SampleW];
    interp_r  = prev_r_q + prod[2*SampleW-1:SampleW];
    frac      = phase_q[2*SampleW-1:SampleW];
    phase_sum = {1'b0, phase_q} + {1'b0, cfg_i.phase_step};
    phase_inc = phase_sum[PhaseW] ? {PhaseW{1'b1}} : phase_sum[PhaseW-1:0];
    cnt_inc   = cnt_q + CntW'(1);
    last_w    = !((phase_inc < PhaseOne) && (cnt_inc < CntW'(MaxOutputs)));
    push      = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  end

  // Route the scaled frame by pan mode
  always_comb begin
    unique case (cfg_i.pan_mode)
      PAN_LEFT: begin
        pan_l = lscale_q;
        pan_r = lscale_q;
      end
      PAN_RIGHT: begin
        pan_l = qval;
        pan_r = qval;
      end
      PAN_MUTE: begin
        pan_l = '0;
        pan_r = '0;
      end
      default: begin
        pan_l = lscale_q;
        pan_r = qval;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_VOL_L;
      S_VOL_L:  state_d = S_DIV_L;
      S_DIV_L:  state_d = S_VOL_R;
      S_VOL_R:  state_d = S_DIV_R;
      S_DIV_R:  state_d = S_LOAD;
      S_LOAD:   state_d = (prime_q == 2'd0) ? S_IDLE : S_CHECK;
      S_CHECK:  state_d = (phase_q < PhaseOne) ? S_INT_L : S_IDLE;
      S_INT_L:  state_d = S_GAIN_L;
      S_GAIN_L: state_d = S_GDIV_L;
      S_GDIV_L: state_d = S_INT_R;
      S_INT_R:  state_d = S_GAIN_R;
      S_GAIN_R: state_d = S_GDIV_R;
      S_GDIV_R: state_d = S_FIN_R;
      S_FIN_R:  state_d = S_EMIT;
      S_EMIT: begin
        if (push) state_d = last_q ? S_IDLE : S_INT_L;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Multiplier operands and handshake outputs
  always_comb begin
    mul_req    = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_VOL_L: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulW'(in_q.source_left);
        mul_req.op_b = MulW'(cfg_i.volume_gain);
      end
      S_VOL_R: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulW'(in_q.source_right);
        mul_req.op_b = MulW'(cfg_i.volume_gain);
      end
      S_DIV_L, S_DIV_R: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulW'(mag);
        mul_req.op_b = Recip127;
      end
      S_INT_L: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulW'(signed'(diff_l));
        mul_req.op_b = MulW'(frac);
      end
      S_INT_R: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulW'(signed'(diff_r));
        mul_req.op_b = MulW'(frac);
      end
      S_GAIN_L: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulW'(signed'(interp_l));
        mul_req.op_b = MulW'(cfg_i.output_gain_percent);
      end
      S_GAIN_R: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulW'(signed'(interp_r));
        mul_req.op_b = MulW'(cfg_i.output_gain_percent);
      end
      S_GDIV_L, S_GDIV_R: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulW'(mag);
        mul_req.op_b = Recip100;
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  // Control state: sequencer, priming, phase, output count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prime_q     <= 2'd0;
      phase_q     <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD) begin
        cnt_q <= '0;
        if (prime_q == 2'd2) begin
          phase_q <= (phase_q >= PhaseOne) ? (phase_q - PhaseOne) : '0;
        end else begin
          prime_q <= prime_q + 2'd1;
        end
      end
      if (state_q == S_FIN_R) begin
        phase_q <= phase_inc;
        cnt_q   <= cnt_inc;
        last_q  <= last_w;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    unique case (state_q)
      S_DIV_L, S_DIV_R, S_GDIV_L, S_GDIV_R: sign_q <= prod[ProdW-1];
      S_VOL_R: lscale_q <= qval;
      S_INT_R: out_l_q  <= qval;
      S_FIN_R: out_r_q  <= qval;
      S_LOAD: begin
        if (prime_q == 2'd0) begin
          prev_l_q <= pan_l;
          prev_r_q <= pan_r;
        end else begin
          if (prime_q == 2'd2) begin
            prev_l_q <= next_l_q;
            prev_r_q <= next_r_q;
          end
          next_l_q <= pan_l;
          next_r_q <= pan_r;
        end
      end
      default: begin
      end
    endcase
    if (push) begin
      out_q.out_left    <= out_l_q;
      out_q.out_right   <= out_r_q;
      out_q.last_of_run <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A stalled emit waits with its frame
  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !out_ready_i) |=> (state_q == S_EMIT))
    else $error("emit left while output slot was occupied");

  // An accepted frame starts the volume multiply
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_VOL_L))
    else $error("accepted frame did not start processing");

  // The last output of a run returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && last_q) |=> (state_q == S_IDLE && out_valid_q))
    else $error("run did not end on its last output");

  // Output count never runs past its limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN_R) |=> (cnt_q != '0 && cnt_q <= CntW'(MaxOutputs)))
    else $error("output count out of range");
`endif

endmodule

[hw/rtl/stereo_linear_resampler_pan_gain.sv]
// ----------------------------------------------------------------------------
// stereo_linear_resampler_pan_gain: linear interpolation rate converter
// Volume-scales and pans stereo source frames, interpolates output frames
// from a 3.32 phase, and applies a percent output gain.
//
//   Channel   Handshake              Payload
//   in        in_valid_i/in_ready_o  in_data_i   (source_left, source_right)
//   out       out_valid_o/out_ready_i out_data_o (out_left, out_right, last)
//   cfg       cfg_we_i               cfg_index_i, cfg_data_i
//
// A source frame passes through volume scaling and a phase check, then the
// interpolation and gain steps for each output frame it yields (up to
// MAX_OUTPUTS_PER_INPUT), all paced by the single shared multiplier.
// A full output register stalls the sequencer in its emit step only.
// Reset is asynchronous: clears control state, loads configuration defaults.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_pan_gain #(
  parameter int unsigned MAX_OUTPUTS_PER_INPUT = slrpg_pkg::MaxOutputsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slrpg_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [slrpg_pkg::PhaseW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  slrpg_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output slrpg_pkg::out_item_t                out_data_o
);
  import slrpg_pkg::*;

  cfg_t cfg_q;

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step          <= PhaseStepReset;
      cfg_q.volume_gain         <= VolumeReset;
      cfg_q.pan_mode            <= PAN_STEREO;
      cfg_q.output_gain_percent <= OutGainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PHASE_STEP:  cfg_q.phase_step          <= cfg_data_i;
        REG_VOLUME_GAIN: cfg_q.volume_gain         <= cfg_data_i[GainW-1:0];
        REG_PAN_MODE:    cfg_q.pan_mode            <= pan_e'(cfg_data_i[PanW-1:0]);
        REG_OUT_GAIN:    cfg_q.output_gain_percent <= cfg_data_i[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  slrpg_seq #(
    .MaxOutputs (MAX_OUTPUTS_PER_INPUT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sim/stereo_linear_resampler_pan_gain_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_linear_resampler_pan_gain_tb: self-checking bench for the resampler
// Drives stereo source frames through a valid/ready channel and compares
// each output frame with a cycle-free predictor of volume, pan,
// interpolation and output gain. A directed table covers priming, field
// extremes, every pan mode, gain saturation and the odd phase steps. Random
// phases with new register settings follow, under random back-pressure.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_pan_gain_tb;
  import slrpg_pkg::*;

  localparam int unsigned FramesPerSourceMax = MaxOutputsDefault;
  localparam int          MaxReports         = 10;
  localparam int          HoldCycles         = 400;
  localparam int          SettleCycles       = 100;
  localparam int          RandomPhases       = 11;
  localparam int          FramesPerPhase     = 30;
  localparam longint      WatchdogNs         = 20_000_000;

  // Phase steps of interest
  localparam logic [PhaseW-1:0] StepUnity = PhaseOne;
  localparam logic [PhaseW-1:0] StepMin   = PhaseW'(64'd536870912);
  localparam logic [PhaseW-1:0] StepMax   = PhaseW'(64'd17179869184);
  localparam logic [PhaseW-1:0] StepTiny  = PhaseW'(64'h1000_0000);
  localparam logic [PhaseW-1:0] StepSat   = '1;
  localparam logic [PhaseW-1:0] PhaseTop  = '1;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  cfg_reg_e  cfg_index_i;
  logic [PhaseW-1:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  stereo_linear_resampler_pan_gain #(
    .MAX_OUTPUTS_PER_INPUT(FramesPerSourceMax)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Predictor copy of the registers and the resampler state
  logic [PhaseW-1:0] step_cfg = PhaseStepReset;
  logic [GainW-1:0]  vol_cfg  = VolumeReset;
  pan_e              pan_cfg  = PAN_STEREO;
  logic [GainW-1:0]  gain_cfg = OutGainReset;

  int                hist_prev_l   = 0;
  int                hist_prev_r   = 0;
  int                hist_next_l   = 0;
  int                hist_next_r   = 0;
  logic [PhaseW-1:0] phase_acc     = '0;
  int                frames_loaded = 0;

  out_item_t frames_due[$];
  int        bad_frames = 0;
  int        out_count  = 0;
  bit        src_calm   = 1'b0;
  bit        sink_calm  = 1'b0;
  bit        hold_req   = 1'b0;

  // Directed stimulus: one register write (optional) ahead of one frame
  typedef struct packed {
    logic               do_write;
    cfg_reg_e           reg_sel;
    logic [PhaseW-1:0]  reg_val;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               typed;
    logic               typed_one;
    logic signed [15:0] typed_left;
    logic signed [15:0] typed_right;
  } plan_row_t;

  localparam int PlanRows = 25;
  localparam plan_row_t DirectedPlan [PlanRows] = '{
    // priming at reset settings: each frame shows the one before it
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 16'h8000},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h8000, 16'h7FFF},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'hFFFF, 16'h0001, 1'b1, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 16'hFFFF, 16'h0001},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'hAAAA, 16'h5555, 1'b1, 1'b1, 16'h5555, 16'hAAAA},
    // pan modes
    '{1'b1, REG_PAN_MODE, PhaseW'(PAN_LEFT), 16'h04D2, 16'hFB2E, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_PAN_MODE, PhaseW'(PAN_RIGHT), 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_PAN_MODE, PhaseW'(PAN_MUTE), 16'h4000, 16'hC000, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_PAN_MODE, PhaseW'(PAN_STEREO), 16'h1000, 16'hF000, 1'b0, 1'b0, 16'h0, 16'h0},
    // source volume extremes
    '{1'b1, REG_VOLUME_GAIN, 35'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_VOLUME_GAIN, 35'd1, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_VOLUME_GAIN, 35'd127, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
    // output gain above unity saturates, then zero and back to unity
    '{1'b1, REG_OUT_GAIN, 35'd127, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_OUT_GAIN, 35'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_OUT_GAIN, 35'd100, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
    // slowest legal step: a full run of outputs per frame
    '{1'b1, REG_PHASE_STEP, StepMin, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
    // fastest legal step: most frames yield nothing
    '{1'b1, REG_PHASE_STEP, StepMax, 16'h1234, 16'h5678, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
    // step too small: outputs dropped, phase subtraction clamps at zero
    '{1'b1, REG_PHASE_STEP, StepTiny, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
    // step of all ones: phase clamps at its top
    '{1'b1, REG_PHASE_STEP, StepSat, 16'h1111, 16'h2222, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b0, REG_PHASE_STEP, 35'd0, 16'h3333, 16'h4444, 1'b0, 1'b0, 16'h0, 16'h0},
    '{1'b1, REG_PHASE_STEP, StepUnity, 16'h7777, 16'h8888, 1'b0, 1'b0, 16'h0, 16'h0}
  };

  // Clock and watchdog
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin : watchdog
    #WatchdogNs;
    $display("FAILED: results differ");
    $finish;
  end

  // Scale a source sample by volume/127, truncating toward zero
  function automatic int scale_by_volume(logic signed [15:0] s);
    return (int'(s) * int'(vol_cfg)) / 127;
  endfunction

  // Interpolate a + floor((b - a) * frac / 2^16)
  function automatic int lerp(int a, int b, logic [15:0] frac);
    longint prod;
    prod = longint'(b - a) * longint'(frac);
    return a + int'(prod >>> 16);
  endfunction

  // Apply output gain in percent, truncating, then saturate to 16 bits
  function automatic logic signed [15:0] apply_out_gain(int s);
    int g;
    g = (s * int'(gain_cfg)) / 100;
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    return 16'(g);
  endfunction

  // Advance the predictor by one source frame and collect its outputs
  function automatic void resample_frame(input in_item_t item, ref out_item_t res[$]);
    int        l, r, fl, fr, n;
    out_item_t o;
    logic [PhaseW:0] sum;
    l = scale_by_volume(item.source_left);
    r = scale_by_volume(item.source_right);
    case (pan_cfg)
      PAN_LEFT: begin
        fl = l;
        fr = l;
      end
      PAN_RIGHT: begin
        fl = r;
        fr = r;
      end
      PAN_MUTE: begin
        fl = 0;
        fr = 0;
      end
      default: begin
        fl = l;
        fr = r;
      end
    endcase
    // first frame only loads the previous slot
    if (frames_loaded == 0) begin
      hist_prev_l   = fl;
      hist_prev_r   = fr;
      frames_loaded = 1;
      return;
    end
    if (frames_loaded == 1) begin
      frames_loaded = 2;
    end else begin
      phase_acc   = (phase_acc >= PhaseOne) ? phase_acc - PhaseOne : '0;
      hist_prev_l = hist_next_l;
      hist_prev_r = hist_next_r;
    end
    hist_next_l = fl;
    hist_next_r = fr;
    n = 0;
    // emit while phase is below one, up to the per-frame cap
    while (phase_acc < PhaseOne && n < FramesPerSourceMax) begin
      o.out_left    = apply_out_gain(lerp(hist_prev_l, hist_next_l, phase_acc[31:16]));
      o.out_right   = apply_out_gain(lerp(hist_prev_r, hist_next_r, phase_acc[31:16]));
      o.last_of_run = 1'b0;
      res.push_back(o);
      sum       = {1'b0, phase_acc} + {1'b0, step_cfg};
      phase_acc = sum[PhaseW] ? PhaseTop : sum[PhaseW-1:0];
      n++;
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
  endfunction

  // Write one configuration register; the block must be idle
  task automatic program_reg(input cfg_reg_e idx, input logic [PhaseW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_PHASE_STEP:  step_cfg = val;
      REG_VOLUME_GAIN: vol_cfg  = val[GainW-1:0];
      REG_PAN_MODE:    pan_cfg  = pan_e'(val[PanW-1:0]);
      default:         gain_cfg = val[GainW-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait for every expected frame, then let the block settle
  task automatic drain_outputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Offer one source frame and record its expected outputs on acceptance
  task automatic push_source_frame(input in_item_t item, input logic typed,
                                   input logic typed_one, input logic signed [15:0] tl,
                                   input logic signed [15:0] tr);
    int        gap;
    out_item_t res[$];
    out_item_t o;
    gap = src_calm ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    // transaction taken at this edge
    resample_frame(item, res);
    if (typed) begin
      if (typed_one) begin
        o.out_left    = tl;
        o.out_right   = tr;
        o.last_of_run = 1'b1;
        frames_due.push_back(o);
      end
    end else begin
      foreach (res[k]) frames_due.push_back(res[k]);
    end
  endtask

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Draw a new register setting and write all four registers
  task automatic program_random_setting(input bit slow_step);
    logic [PhaseW-1:0] step;
    logic [63:0]       span;
    logic [GainW-1:0]  vol, gain;
    span = 64'(StepMax) - 64'(StepMin) + 64'd1;
    case ($urandom_range(0, 9))
      0:       step = StepMin;
      1:       step = StepMax;
      2:       step = StepUnity;
      3:       step = '0;
      4:       step = StepSat;
      5:       step = PhaseW'($urandom_range(1, 536870911));
      default: step = PhaseW'(64'(StepMin) + ({$urandom, $urandom} % span));
    endcase
    if (slow_step) step = StepMin;
    case ($urandom_range(0, 5))
      0:       vol = '0;
      1:       vol = GainW'(127);
      default: vol = GainW'($urandom_range(0, 127));
    endcase
    case ($urandom_range(0, 5))
      0:       gain = '0;
      1:       gain = GainW'(100);
      2:       gain = GainW'($urandom_range(101, 127));
      default: gain = GainW'($urandom_range(0, 100));
    endcase
    program_reg(REG_PHASE_STEP, step);
    program_reg(REG_VOLUME_GAIN, PhaseW'(vol));
    program_reg(REG_PAN_MODE, PhaseW'(pan_e'($urandom_range(0, 3))));
    program_reg(REG_OUT_GAIN, PhaseW'(gain));
  endtask

  // Receiver: draw a stall after each transaction, or a long hold on request
  initial begin : sink_ready
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      stall = sink_calm ? 0 : $urandom_range(0, 18);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HoldCycles;
      end
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest expected frame
  always @(posedge clk_i) begin : check_outputs
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_count++;
      if (frames_due.size() == 0) begin
        bad_frames++;
        if (bad_frames <= MaxReports)
          $display("output %0d unexpected: L=%0d R=%0d last=%0b", out_count,
                   out_data_o.out_left, out_data_o.out_right, out_data_o.last_of_run);
      end else begin
        want = frames_due.pop_front();
        if (out_data_o.out_left !== want.out_left ||
            out_data_o.out_right !== want.out_right ||
            out_data_o.last_of_run !== want.last_of_run) begin
          bad_frames++;
          if (bad_frames <= MaxReports)
            $display("output %0d mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                     out_count, want.out_left, want.out_right, want.last_of_run,
                     out_data_o.out_left, out_data_o.out_right, out_data_o.last_of_run);
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases
  initial begin : stimulus
    in_item_t item;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_PHASE_STEP;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedPlan[i]) begin
      if (DirectedPlan[i].do_write) begin
        drain_outputs();
        program_reg(DirectedPlan[i].reg_sel, DirectedPlan[i].reg_val);
      end
      item.source_left  = DirectedPlan[i].left;
      item.source_right = DirectedPlan[i].right;
      push_source_frame(item, DirectedPlan[i].typed, DirectedPlan[i].typed_one,
                        DirectedPlan[i].typed_left, DirectedPlan[i].typed_right);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      drain_outputs();
      program_random_setting(p == 3);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      // hold the receiver off while the sender keeps offering frames
      if (p == 3) begin
        src_calm = 1'b1;
        hold_req = 1'b1;
      end
      for (int k = 0; k < FramesPerPhase; k++) begin
        // pause the sender mid-phase until every output is in
        if (p == 6 && k == FramesPerPhase / 2) drain_outputs();
        item.source_left  = random_sample();
        item.source_right = random_sample();
        push_source_frame(item, 1'b0, 1'b0, '0, '0);
      end
    end

    drain_outputs();
    if (bad_frames == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
